// ===== src/sktab_pkg.sv =====
// Shared types, codes and a helper function for the sorted key table search unit.
`timescale 1ns / 1ps

package sktab_pkg;

    // Fixed field widths
    localparam int KEY_W      = 64;
    localparam int OFFSET_W   = 32;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int BYTES_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    // Transaction kinds
    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_EXACT  = 2'd1,
        KIND_PREFIX = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_COUNT    = 4'd0,
        CFG_MAX_NAME_BYTES = 4'd1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [INDEX_W-1:0]  entry_index;
        logic [KEY_W-1:0]    key;
        logic [BYTES_W-1:0]  prefix_len;
        logic [OFFSET_W-1:0] offset_value;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  match_index;
        logic [OFFSET_W-1:0] offset_out;
    } rsp_t;

    // Mask of the n leading bytes of a key that is key_bytes long
    // (leading byte sits at the top of the used part of the word).
    function automatic logic [KEY_W-1:0] lead_mask(
        input logic [BYTES_W-1:0] n,
        input logic [BYTES_W-1:0] key_bytes
    );
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if ((b < int'(key_bytes)) && (b >= int'(key_bytes) - int'(n))) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== src/sktab_table.sv =====
// Key and offset table: one write port, one read port with registered data.
`timescale 1ns / 1ps

module sktab_table #(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [IDX_W-1:0]               wr_addr,
    input  logic [sktab_pkg::KEY_W-1:0]    wr_key,
    input  logic [sktab_pkg::OFFSET_W-1:0] wr_offset,
    input  logic                           rd_en,
    input  logic [IDX_W-1:0]               rd_addr,
    output logic [sktab_pkg::KEY_W-1:0]    rd_key,
    output logic [sktab_pkg::OFFSET_W-1:0] rd_offset
);

    logic [sktab_pkg::KEY_W-1:0]    key_mem    [DEPTH];
    logic [sktab_pkg::OFFSET_W-1:0] offset_mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]    <= wr_key;
            offset_mem[wr_addr] <= wr_offset;
        end
    end

    // read port, data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key    <= key_mem[rd_addr];
            rd_offset <= offset_mem[rd_addr];
        end
    end

endmodule

// ===== src/sorted_key_table_search_unit.sv =====
// Top level of the sorted key table search unit: sequencer, comparator and registers.
`timescale 1ns / 1ps

// Holds a table of TABLE_DEPTH keys (KEY_BYTES bytes, first byte most
// significant, zero padded) sorted ascending, each with a 32-bit offset.
// A load transaction writes one entry and returns nothing. An exact or
// prefix lookup returns one transaction: found, match_index and
// offset_out (index and offset are zero on a miss). A lookup occupies the
// unit, which holds req_stall high until it finishes. It accepts the
// request, checks the first entry, then the last entry, then bisects the
// entries between them (about log2(entry_count) probes, each a midpoint
// step and a compare step), finds the interval empty on a miss, on a
// prefix hit checks entries on the walk back (the entries passed plus the
// one that ends the walk, unless it reaches index 0), and posts the result.
// A result stalled downstream holds the unit in the posting state. Lookups
// run one at a time, as the single table read port feeds the one shared
// key comparator. Kind 3 is dropped. Configuration writes are always taken
// and must be done while no lookup is in flight.

module sorted_key_table_search_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BYTES   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  sktab_pkg::req_t                     req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output sktab_pkg::rsp_t                     rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sktab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sktab_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [sktab_pkg::KEY_W-1:0] KEY_MASK =
        sktab_pkg::lead_mask(sktab_pkg::BYTES_W'(KEY_BYTES),
                             sktab_pkg::BYTES_W'(KEY_BYTES));

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_LAST  = 7'b0000100,
        S_MID   = 7'b0001000,
        S_BIS   = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [sktab_pkg::COUNT_W-1:0] entry_count_reg;
    logic [sktab_pkg::BYTES_W-1:0] max_name_reg;

    // lookup context
    logic [sktab_pkg::KEY_W-1:0]    probe_reg, probe_next;
    logic [sktab_pkg::KEY_W-1:0]    mask_reg, mask_next;
    logic                           prefix_reg, prefix_next;
    logic [IDX_W-1:0]               last_reg, last_next;
    logic [IDX_W-1:0]               s_reg, s_next;
    logic [IDX_W-1:0]               e_reg, e_next;
    logic [IDX_W-1:0]               m_reg, m_next;
    logic [IDX_W-1:0]               ix_reg, ix_next;
    logic [sktab_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic                           found_reg, found_next;

    // result register
    logic            rsp_valid_reg;
    sktab_pkg::rsp_t rsp_data_reg;

    // table ports
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic [sktab_pkg::KEY_W-1:0]    rd_key;
    logic [sktab_pkg::OFFSET_W-1:0] rd_offset;

    // misc
    logic                          req_take;
    logic                          rsp_load;
    logic [sktab_pkg::BYTES_W-1:0] n_bytes;
    logic [31:0]                   count_wide;
    logic [IDX_W-1:0]              last_calc;
    logic [IDX_W:0]                mid_sum;
    logic [IDX_W-1:0]              mid;
    logic [sktab_pkg::KEY_W-1:0]   cmp_b;
    logic                          cmp_eq;
    logic                          cmp_gt;
    logic                          hit;
    logic [IDX_W-1:0]              hit_ix;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= sktab_pkg::COUNT_W'(1);
            max_name_reg    <= sktab_pkg::BYTES_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sktab_pkg::CFG_ENTRY_COUNT:
                    entry_count_reg <= cfg_data[sktab_pkg::COUNT_W-1:0];
                sktab_pkg::CFG_MAX_NAME_BYTES:
                    max_name_reg <= cfg_data[sktab_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // table write on load
    assign wr_en   = req_take && (req_data.kind == sktab_pkg::KIND_LOAD)
                     && (32'(req_data.entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr = IDX_W'(req_data.entry_index);

    sktab_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (req_data.key & KEY_MASK),
        .wr_offset (req_data.offset_value),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_offset (rd_offset)
    );

    // effective prefix length and last index
    always_comb
    begin
        n_bytes = req_data.prefix_len;
        if (n_bytes > max_name_reg)
            n_bytes = max_name_reg;
        if (n_bytes > sktab_pkg::BYTES_W'(KEY_BYTES))
            n_bytes = sktab_pkg::BYTES_W'(KEY_BYTES);
        count_wide = 32'(entry_count_reg);
        if (count_wide == 32'd0)
            last_calc = '0;
        else if (count_wide > 32'(TABLE_DEPTH))
            last_calc = LAST_MAX;
        else
            last_calc = IDX_W'(count_wide - 32'd1);
    end

    // shared comparator: masked probe against masked stored key
    assign cmp_b  = rd_key & mask_reg;
    assign cmp_eq = (probe_reg == cmp_b);
    assign cmp_gt = (probe_reg > cmp_b);

    // bisection midpoint
    assign mid_sum = {1'b0, s_reg} + {1'b0, e_reg};
    assign mid     = mid_sum[IDX_W:1];

    // hit detection in the probing states
    always_comb
    begin
        hit    = 1'b0;
        hit_ix = '0;
        unique case (state_reg)
            S_FIRST:
            begin
                hit    = cmp_eq;
                hit_ix = '0;
            end
            S_LAST:
            begin
                hit    = cmp_eq;
                hit_ix = last_reg;
            end
            S_BIS:
            begin
                hit    = cmp_eq;
                hit_ix = m_reg;
            end
            default: ;
        endcase
    end

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        probe_next  = probe_reg;
        mask_next   = mask_reg;
        prefix_next = prefix_reg;
        last_next   = last_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        m_next      = m_reg;
        ix_next     = ix_reg;
        off_next    = off_reg;
        found_next  = found_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take && ((req_data.kind == sktab_pkg::KIND_EXACT)
                                 || (req_data.kind == sktab_pkg::KIND_PREFIX)))
                begin
                    prefix_next = (req_data.kind == sktab_pkg::KIND_PREFIX);
                    mask_next   = prefix_next
                                  ? sktab_pkg::lead_mask(n_bytes,
                                        sktab_pkg::BYTES_W'(KEY_BYTES))
                                  : KEY_MASK;
                    probe_next  = req_data.key & mask_next;
                    last_next   = last_calc;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    state_next  = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (!cmp_eq)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = last_reg;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!cmp_eq)
                begin
                    s_next     = '0;
                    e_next     = last_reg;
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                if ((mid == s_reg) || (mid == e_reg))
                begin
                    found_next = 1'b0;
                    ix_next    = '0;
                    off_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    m_next     = mid;
                    rd_en      = 1'b1;
                    rd_addr    = mid;
                    state_next = S_BIS;
                end
            end
            S_BIS:
            begin
                if (!cmp_eq)
                begin
                    if (cmp_gt)
                        s_next = m_reg;
                    else
                        e_next = m_reg;
                    state_next = S_MID;
                end
            end
            S_WALK:
            begin
                // entry ix_reg-1 is on the read port
                if (cmp_eq)
                begin
                    ix_next  = ix_reg - IDX_W'(1);
                    off_next = rd_offset;
                    if (ix_next != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ix_next - IDX_W'(1);
                    end
                    else
                        state_next = S_DONE;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // common hit path
        if (hit)
        begin
            found_next = 1'b1;
            ix_next    = hit_ix;
            off_next   = rd_offset;
            if (prefix_reg && (hit_ix != '0))
            begin
                rd_en      = 1'b1;
                rd_addr    = hit_ix - IDX_W'(1);
                state_next = S_WALK;
            end
            else
                state_next = S_DONE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        probe_reg  <= probe_next;
        mask_reg   <= mask_next;
        prefix_reg <= prefix_next;
        last_reg   <= last_next;
        s_reg      <= s_next;
        e_reg      <= e_next;
        m_reg      <= m_next;
        ix_reg     <= ix_next;
        off_reg    <= off_next;
        found_reg  <= found_next;
        if (rsp_load)
        begin
            rsp_data_reg.found       <= found_reg;
            rsp_data_reg.match_index <= sktab_pkg::INDEX_W'(ix_reg);
            rsp_data_reg.offset_out  <= off_reg;
        end
    end

    // assertions
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.found |->
            (rsp_data.match_index == '0) && (rsp_data.offset_out == '0))
        else $error("miss reported with nonzero index or offset");

    a_probe_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BIS |-> (m_reg > s_reg) && (m_reg < e_reg))
        else $error("bisection probe outside open interval");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MID |-> (s_reg <= e_reg))
        else $error("bisection bounds crossed");

    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && cmp_eq |=> (ix_reg + IDX_W'(1)) == $past(ix_reg))
        else $error("walk-back did not step down by one");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("result posted outside completion state");

endmodule

// ===== bench/sorted_key_table_search_unit_test.sv =====
// Self-checking testbench for the sorted key table search unit.
`timescale 1ns / 1ps

module sorted_key_table_search_unit_test;

    localparam int TABLE_DEPTH  = 1024;
    localparam int KEY_BYTES    = 8;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             req_valid = 1'b0;
    logic                             req_stall;
    sktab_pkg::req_t                  req_data = '0;
    logic                             rsp_valid;
    logic                             rsp_stall = 1'b0;
    sktab_pkg::rsp_t                  rsp_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [sktab_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sktab_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Transactions waiting to be driven, and lookup results still owed
    sktab_pkg::req_t pending[$];
    sktab_pkg::rsp_t expected_rsp[$];

    // Table contents as seen by accepted loads, and the table being planned
    bit [sktab_pkg::KEY_W-1:0]    tab_key  [TABLE_DEPTH];
    bit [sktab_pkg::OFFSET_W-1:0] tab_off  [TABLE_DEPTH];
    bit [sktab_pkg::KEY_W-1:0]    plan_key [TABLE_DEPTH];
    logic [sktab_pkg::COUNT_W-1:0] cur_count = 11'd1;
    logic [sktab_pkg::BYTES_W-1:0] cur_name_bytes = 4'd8;

    bit req_taken;
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int send_gap;
    int stall_left;
    int errors;
    int cycles;

    sorted_key_table_search_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Unsigned order of two keys over the full key or its n leading bytes
    function automatic int key_order(input logic [sktab_pkg::KEY_W-1:0] a,
                                     input logic [sktab_pkg::KEY_W-1:0] b,
                                     input int n, input bit pfx);
        logic [sktab_pkg::KEY_W-1:0] x;
        logic [sktab_pkg::KEY_W-1:0] y;
        x = a;
        y = b;
        if (pfx)
        begin
            if (n == 0)
                return 0;
            x = a >> (8 * (KEY_BYTES - n));
            y = b >> (8 * (KEY_BYTES - n));
        end
        if (x > y)
            return 1;
        if (x < y)
            return -1;
        return 0;
    endfunction

    // Expected result of an exact or prefix lookup against the current table
    function automatic sktab_pkg::rsp_t lookup_model(input sktab_pkg::req_t r);
        sktab_pkg::rsp_t res;
        int   last;
        int   n;
        int   s;
        int   e;
        int   m;
        int   ix;
        int   c;
        bit   hit;
        bit   pfx;
        pfx = (r.kind == sktab_pkg::KIND_PREFIX);
        n = int'(r.prefix_len);
        if (n > int'(cur_name_bytes))
            n = int'(cur_name_bytes);
        if (n > KEY_BYTES)
            n = KEY_BYTES;
        last = int'(cur_count);
        if (last == 0)
            last = 1;
        if (last > TABLE_DEPTH)
            last = TABLE_DEPTH;
        last = last - 1;
        hit = 1'b0;
        ix = 0;
        // first entry, then last entry, then bisect what lies between
        if (key_order(r.key, tab_key[0], n, pfx) == 0)
            hit = 1'b1;
        else if (key_order(r.key, tab_key[last], n, pfx) == 0)
        begin
            hit = 1'b1;
            ix = last;
        end
        else
        begin
            s = 0;
            e = last;
            m = (s + e) / 2;
            while (!hit && m != s && m != e)
            begin
                c = key_order(r.key, tab_key[m], n, pfx);
                if (c == 0)
                begin
                    hit = 1'b1;
                    ix = m;
                end
                else
                begin
                    if (c > 0)
                        s = m;
                    else
                        e = m;
                    m = (s + e) / 2;
                end
            end
        end
        // prefix hit: back up to the first entry sharing the prefix
        if (hit && pfx)
        begin
            while (ix > 0 && key_order(r.key, tab_key[ix-1], n, 1'b1) == 0)
                ix--;
        end
        res.found       = hit;
        res.match_index = hit ? ix[sktab_pkg::INDEX_W-1:0] : '0;
        res.offset_out  = hit ? tab_off[ix] : '0;
        return res;
    endfunction

    // Name-like key: short runs from a small alphabet so prefixes repeat
    function automatic logic [sktab_pkg::KEY_W-1:0] make_name();
        logic [sktab_pkg::KEY_W-1:0] k;
        logic [7:0]                  ch;
        int                          len;
        k = '0;
        len = $urandom_range(1, KEY_BYTES);
        for (int b = 0; b < len; b++)
        begin
            case ($urandom_range(0, 7))
                0: ch = 8'h41;
                1: ch = 8'h42;
                2: ch = 8'h43;
                3: ch = 8'h61;
                4: ch = 8'hFF;
                5: ch = 8'h00;
                default: ch = 8'($urandom);
            endcase
            k[sktab_pkg::KEY_W-1-8*b -: 8] = ch;
        end
        return k;
    endfunction

    task automatic post_req(input sktab_pkg::kind_t kind,
                            input logic [sktab_pkg::INDEX_W-1:0] idx,
                            input logic [sktab_pkg::KEY_W-1:0] key,
                            input logic [sktab_pkg::BYTES_W-1:0] plen,
                            input logic [sktab_pkg::OFFSET_W-1:0] off);
        sktab_pkg::req_t r;
        r.kind         = kind;
        r.entry_index  = idx;
        r.key          = key;
        r.prefix_len   = plen;
        r.offset_value = off;
        pending.push_back(r);
    endtask

    // Wait until every transaction is sent and every result is back
    task automatic drain();
        do
            @(posedge clk);
        while (pending.size() != 0 || req_valid || expected_rsp.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input sktab_pkg::cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[sktab_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == sktab_pkg::CFG_ENTRY_COUNT)
            cur_count = value[sktab_pkg::COUNT_W-1:0];
        else
            cur_name_bytes = value[sktab_pkg::BYTES_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Fill entries 0..cnt-1 with fresh keys, ascending unless told otherwise
    task automatic load_table(input int cnt, input bit ordered);
        logic [sktab_pkg::KEY_W-1:0] k;
        int                          j;
        for (int i = 0; i < cnt; i++)
        begin
            k = make_name();
            j = i;
            while (ordered && j > 0 && plan_key[j-1] > k)
            begin
                plan_key[j] = plan_key[j-1];
                j--;
            end
            plan_key[j] = k;
        end
        for (int i = 0; i < cnt; i++)
            post_req(sktab_pkg::KIND_LOAD, sktab_pkg::INDEX_W'(i), plan_key[i],
                     sktab_pkg::BYTES_W'($urandom), $urandom);
    endtask

    // One configuration setting: new table, then random lookups with some noise
    task automatic run_phase(input int count, input int name_bytes, input bit ordered,
                             input int lookups);
        int                            last;
        int                            ix;
        int                            sel;
        int                            done;
        logic [sktab_pkg::KEY_W-1:0]   k;
        logic [sktab_pkg::BYTES_W-1:0] plen;
        sktab_pkg::kind_t              kd;
        drain();
        cfg_write(sktab_pkg::CFG_ENTRY_COUNT, count);
        cfg_write(sktab_pkg::CFG_MAX_NAME_BYTES, name_bytes);
        if (count == 0)
            last = 0;
        else if (count > TABLE_DEPTH)
            last = TABLE_DEPTH - 1;
        else
            last = count - 1;
        load_table(last + 1, ordered);
        done = 0;
        while (done < lookups)
        begin
            sel = $urandom_range(0, 99);
            ix = $urandom_range(0, last);
            if (sel < 5)
                post_req(sktab_pkg::KIND_NONE, sktab_pkg::INDEX_W'($urandom),
                         {$urandom, $urandom}, sktab_pkg::BYTES_W'($urandom), $urandom);
            else if (sel < 9)
                // same key, new offset: table stays sorted
                post_req(sktab_pkg::KIND_LOAD, sktab_pkg::INDEX_W'(ix), plan_key[ix],
                         sktab_pkg::BYTES_W'($urandom), $urandom);
            else if (sel < 11 && last < TABLE_DEPTH - 1)
                // entry outside the live range
                post_req(sktab_pkg::KIND_LOAD,
                         sktab_pkg::INDEX_W'($urandom_range(last + 1, TABLE_DEPTH - 1)),
                         {$urandom, $urandom}, sktab_pkg::BYTES_W'($urandom), $urandom);
            else
            begin
                k = plan_key[ix];
                case ($urandom_range(0, 4))
                    0, 1: ;
                    2: k[8*$urandom_range(0, 7) +: 8] = 8'($urandom);
                    3: k = ($urandom_range(0, 1) != 0) ? k + 64'd1 : k - 64'd1;
                    default: k = make_name();
                endcase
                if ($urandom_range(0, 7) == 0)
                    plen = sktab_pkg::BYTES_W'($urandom_range(0, 15));
                else
                    plen = sktab_pkg::BYTES_W'($urandom_range(1, KEY_BYTES));
                if ($urandom_range(0, 1) != 0)
                    kd = sktab_pkg::KIND_PREFIX;
                else
                    kd = sktab_pkg::KIND_EXACT;
                post_req(kd, sktab_pkg::INDEX_W'($urandom), k, plen, $urandom);
                done++;
            end
        end
    endtask

    task automatic flag_error(input string what, input sktab_pkg::rsp_t want,
                              input sktab_pkg::rsp_t got);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s: expected found=%0d index=%0d offset=%h, %s%0d %s%0d %s%h",
                     $time, what, want.found, want.match_index, want.offset_out,
                     "got found=", got.found, "index=", got.match_index,
                     "offset=", got.offset_out);
    endtask

    // Request driver: one transaction at a time from the pending queue
    always @(negedge clk)
    begin : drive_req
        logic            next_valid;
        sktab_pkg::req_t next_data;
        next_valid = req_valid && !req_taken;
        next_data  = req_data;
        if (!next_valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending.size() != 0)
            begin
                next_data  = pending.pop_front();
                next_valid = 1'b1;
                send_gap   = pick_gap(send_idle);
            end
        end
        req_valid <= next_valid;
        req_data  <= next_data;
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        if (stall_left == 0)
            stall_left = ($urandom_range(0, 2) == 0) ? pick_gap(recv_idle) : 0;
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : monitor
        sktab_pkg::rsp_t want;
        req_taken = rst_n && req_valid && !req_stall;
        if (req_taken)
        begin
            if (req_data.kind == sktab_pkg::KIND_LOAD)
            begin
                tab_key[req_data.entry_index] = req_data.key;
                tab_off[req_data.entry_index] = req_data.offset_value;
            end
            else if (req_data.kind != sktab_pkg::KIND_NONE)
                expected_rsp.push_back(lookup_model(req_data));
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
                flag_error("result with no lookup outstanding", '0, rsp_data);
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_data.found !== want.found
                    || rsp_data.match_index !== want.match_index
                    || rsp_data.offset_out !== want.offset_out)
                    flag_error("lookup result mismatch", want, rsp_data);
            end
        end
    end

    // Watchdog, and occasional switching of idle behavior on each side
    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 256 == 0)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_key_table_search_unit_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration: one live entry
        post_req(sktab_pkg::KIND_LOAD, 10'd0, 64'h0, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_EXACT, 10'd0, 64'h0, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_PREFIX, 10'd0, 64'h4100_0000_0000_0000, 4'd8, 32'h0);
        drain();

        // small hand-built table with a duplicate and shared prefixes
        cfg_write(sktab_pkg::CFG_ENTRY_COUNT, 6);
        cfg_write(sktab_pkg::CFG_MAX_NAME_BYTES, 8);
        post_req(sktab_pkg::KIND_LOAD, 10'd1, 64'h4142_0000_0000_0000, 4'd0, 32'h0000_1111);
        post_req(sktab_pkg::KIND_LOAD, 10'd2, 64'h4142_4300_0000_0000, 4'd0, 32'h0000_2222);
        post_req(sktab_pkg::KIND_LOAD, 10'd3, 64'h4142_4400_0000_0000, 4'd0, 32'h0000_3333);
        post_req(sktab_pkg::KIND_LOAD, 10'd4, 64'h4142_4400_0000_0000, 4'd0, 32'h0000_4444);
        post_req(sktab_pkg::KIND_LOAD, 10'd5, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        post_req(sktab_pkg::KIND_LOAD, 10'd0, 64'h0, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_LOAD, 10'd1023, 64'h5A5A_5A5A_5A5A_5A5A, 4'd0, 32'hA5A5_A5A5);
        post_req(sktab_pkg::KIND_EXACT, 10'd0, 64'h0, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_EXACT, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_EXACT, 10'd0, 64'h4142_4300_0000_0000, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_EXACT, 10'd0, 64'h4142_4400_0000_0000, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_EXACT, 10'd0, 64'h4142_4200_0000_0000, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_EXACT, 10'd0, 64'h0100_0000_0000_0000, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_PREFIX, 10'd0, 64'h4142_FFFF_FFFF_FFFF, 4'd2, 32'h0);
        post_req(sktab_pkg::KIND_PREFIX, 10'd0, 64'h4142_4477_0000_0000, 4'd3, 32'h0);
        post_req(sktab_pkg::KIND_PREFIX, 10'd0, 64'h1234_5678_9ABC_DEF0, 4'd0, 32'h0);
        post_req(sktab_pkg::KIND_PREFIX, 10'd0, 64'h4142_4300_0000_0000, 4'hF, 32'h0);
        post_req(sktab_pkg::KIND_PREFIX, 10'd0, 64'h5A00_0000_0000_0000, 4'd1, 32'h0);
        post_req(sktab_pkg::KIND_PREFIX, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        post_req(sktab_pkg::KIND_NONE, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 32'hFFFF_FFFF);

        // random lookups over a range of table sizes and prefix caps
        run_phase(3, 8, 1'b1, 30);
        run_phase(0, 8, 1'b1, 20);
        run_phase(2, 1, 1'b1, 30);
        run_phase(17, 3, 1'b1, 40);
        run_phase(1, 15, 1'b1, 20);
        run_phase(32, 0, 1'b1, 30);
        run_phase(100, 8, 1'b1, 30);
        run_phase(40, 5, 1'b0, 30);
        run_phase(24, 2, 1'b1, 30);
        run_phase(9, 4, 1'b1, 30);

        drain();
        if (errors == 0 && expected_rsp.size() == 0)
            $display("sorted_key_table_search_unit_test: PASS");
        else
            $display("sorted_key_table_search_unit_test: FAIL");
        $finish;
    end

endmodule
